@@ rtl/core/bfbb_pkg.sv @@
// ----------------------------------------------------------------------------
// bfbb_pkg
// Shared types and codes for the best-fit buffer bank.
// ----------------------------------------------------------------------------
package bfbb_pkg;

  typedef enum logic {
    OP_ASSIGN  = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    STATUS_REUSED   = 3'd0,
    STATUS_APPENDED = 3'd1,
    STATUS_FULL     = 3'd2,
    STATUS_RELEASED = 3'd3,
    STATUS_BAD_IDX  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_SCAN,
    CS_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic valid;
    op_t  op;
    logic found;
  } scan_ctl_t;

  typedef struct packed {
    logic write;
    logic set_busy;
    logic clr_busy;
  } commit_t;

  localparam int REUSE_SHIFT = 3;

endpackage

@@ rtl/core/bfbb_req_if.sv @@
// ----------------------------------------------------------------------------
// bfbb_req_if
// Request channel: operation, size and release index with valid/ready.
// ----------------------------------------------------------------------------
interface bfbb_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [23:0] request_size;
  logic [5:0]  release_index;

  modport source (output valid, output operation, output request_size,
                  output release_index, input ready);
  modport sink (input valid, input operation, input request_size,
                input release_index, output ready);
endinterface

@@ rtl/core/bfbb_rsp_if.sv @@
// ----------------------------------------------------------------------------
// bfbb_rsp_if
// Result channel: status, entry index and entry size with valid/ready.
// ----------------------------------------------------------------------------
interface bfbb_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [5:0]  entry_index;
  logic [23:0] entry_size;

  modport source (output valid, output status, output entry_index,
                  output entry_size, input ready);
  modport sink (input valid, input status, input entry_index,
                input entry_size, output ready);
endinterface

@@ rtl/core/best_fit_buffer_bank_top.sv @@
// Flow: an assign or a release passes through the row of ENTRIES cells, the
//   controller registers the tail, then the result once the output is free;
//   a release with an index beyond the live entries skips the row. No new
//   request is taken until the result of the last one has been registered.
// Reset: synchronous, clears busy/live marks, entry count and handshake state;
//   stored sizes are not cleared and are read only after being written.
// ----------------------------------------------------------------------------
// best_fit_buffer_bank_top
// Best-fit buffer table: a row of entry cells scanned by a travelling
// candidate, with a controller that decides reuse, append, full or release.
// ----------------------------------------------------------------------------
module best_fit_buffer_bank_top #(
  parameter int ENTRIES   = 64,
  parameter int SIZE_BITS = 24
) (
  input logic        clk,
  input logic        rst,
  bfbb_req_if.sink   request,
  bfbb_rsp_if.source result
);

  localparam int IDXW = $clog2(ENTRIES);
  localparam int CNTW = $clog2(ENTRIES + 1);

  bfbb_pkg::scan_ctl_t  ctl_bus  [ENTRIES+1];
  logic [SIZE_BITS-1:0] req_bus  [ENTRIES+1];
  logic [IDXW-1:0]      best_bus [ENTRIES+1];
  logic [SIZE_BITS-1:0] size_bus [ENTRIES+1];

  bfbb_pkg::commit_t    commit;
  logic [IDXW-1:0]      commit_idx;
  logic [SIZE_BITS-1:0] commit_size;

  bfbb_ctrl #(
    .ENTRIES   (ENTRIES),
    .SIZE_BITS (SIZE_BITS),
    .IDXW      (IDXW),
    .CNTW      (CNTW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .request     (request),
    .result      (result),
    .head_ctl    (ctl_bus[0]),
    .head_req    (req_bus[0]),
    .head_best   (best_bus[0]),
    .head_size   (size_bus[0]),
    .tail_ctl    (ctl_bus[ENTRIES]),
    .tail_req    (req_bus[ENTRIES]),
    .tail_best   (best_bus[ENTRIES]),
    .tail_size   (size_bus[ENTRIES]),
    .commit      (commit),
    .commit_idx  (commit_idx),
    .commit_size (commit_size)
  );

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    bfbb_cell #(
      .SIZE_BITS (SIZE_BITS),
      .IDXW      (IDXW),
      .IDX       (g)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .in_ctl      (ctl_bus[g]),
      .in_req      (req_bus[g]),
      .in_best     (best_bus[g]),
      .in_size     (size_bus[g]),
      .out_ctl     (ctl_bus[g+1]),
      .out_req     (req_bus[g+1]),
      .out_best    (best_bus[g+1]),
      .out_size    (size_bus[g+1]),
      .commit      (commit),
      .commit_idx  (commit_idx),
      .commit_size (commit_size)
    );
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    request.valid && request.ready |=> !request.ready)
    else $error("request taken while another is in flight");

  a_tail_while_busy: assert property (@(posedge clk) disable iff (rst)
    ctl_bus[ENTRIES].valid |-> !request.ready)
    else $error("scan finished with controller idle");

  a_single_commit: assert property (@(posedge clk) disable iff (rst)
    $onehot0({commit.write, commit.set_busy, commit.clr_busy}))
    else $error("more than one table update at once");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.status == bfbb_pkg::STATUS_FULL ||
                     result.status == bfbb_pkg::STATUS_BAD_IDX)
    |-> result.entry_index == 6'd0 && result.entry_size == 24'd0)
    else $error("failed result carries nonzero index or size");

endmodule

@@ rtl/core/bfbb_cell.sv @@
// ----------------------------------------------------------------------------
// bfbb_cell
// One table entry. Holds size, busy and live marks, updates the passing
// best-fit candidate and registers it toward the next cell.
// ----------------------------------------------------------------------------
module bfbb_cell #(
  parameter int SIZE_BITS = 24,
  parameter int IDXW      = 6,
  parameter int IDX       = 0
) (
  input  logic                     clk,
  input  logic                     rst,
  input  bfbb_pkg::scan_ctl_t      in_ctl,
  input  logic [SIZE_BITS-1:0]     in_req,
  input  logic [IDXW-1:0]          in_best,
  input  logic [SIZE_BITS-1:0]     in_size,
  output bfbb_pkg::scan_ctl_t      out_ctl,
  output logic [SIZE_BITS-1:0]     out_req,
  output logic [IDXW-1:0]          out_best,
  output logic [SIZE_BITS-1:0]     out_size,
  input  bfbb_pkg::commit_t        commit,
  input  logic [IDXW-1:0]          commit_idx,
  input  logic [SIZE_BITS-1:0]     commit_size
);

  logic [SIZE_BITS-1:0] size;
  logic                 busy;
  logic                 live;
  logic                 hit;
  logic                 cand;
  logic                 here;

  assign hit  = (in_best == IDXW'(IDX));
  assign here = (commit_idx == IDXW'(IDX));
  assign cand = in_ctl.valid && (in_ctl.op == bfbb_pkg::OP_ASSIGN) && live && !busy &&
                (in_req <= size) && (!in_ctl.found || (size < in_size));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      live <= 1'b0;
    end else if (here) begin
      if (commit.write) begin
        live <= 1'b1;
        busy <= 1'b1;
      end else if (commit.set_busy) begin
        busy <= 1'b1;
      end else if (commit.clr_busy) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit.write && here) begin
      size <= commit_size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl.valid <= 1'b0;
    end else begin
      out_ctl.valid <= in_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_ctl.op    <= in_ctl.op;
    out_ctl.found <= in_ctl.found | cand;
    out_req       <= in_req;
    out_best      <= cand ? IDXW'(IDX) : in_best;
    if (cand || (in_ctl.op == bfbb_pkg::OP_RELEASE && hit)) begin
      out_size <= size;
    end else begin
      out_size <= in_size;
    end
  end

endmodule

@@ rtl/core/bfbb_ctrl.sv @@
// ----------------------------------------------------------------------------
// bfbb_ctrl
// Request intake, entry count, final decision and result register.
// ----------------------------------------------------------------------------
module bfbb_ctrl #(
  parameter int ENTRIES   = 64,
  parameter int SIZE_BITS = 24,
  parameter int IDXW      = 6,
  parameter int CNTW      = 7
) (
  input  logic                 clk,
  input  logic                 rst,
  bfbb_req_if.sink             request,
  bfbb_rsp_if.source           result,
  output bfbb_pkg::scan_ctl_t  head_ctl,
  output logic [SIZE_BITS-1:0] head_req,
  output logic [IDXW-1:0]      head_best,
  output logic [SIZE_BITS-1:0] head_size,
  input  bfbb_pkg::scan_ctl_t  tail_ctl,
  input  logic [SIZE_BITS-1:0] tail_req,
  input  logic [IDXW-1:0]      tail_best,
  input  logic [SIZE_BITS-1:0] tail_size,
  output bfbb_pkg::commit_t    commit,
  output logic [IDXW-1:0]      commit_idx,
  output logic [SIZE_BITS-1:0] commit_size
);

  bfbb_pkg::ctrl_state_t state, state_next;

  logic [CNTW-1:0]        count;
  logic                   accept;
  logic                   is_release;
  logic                   bad_index;
  logic [SIZE_BITS+23:0]  req_wide;
  logic [CNTW+5:0]        rel_wide;
  logic [CNTW+5:0]        cnt_wide;
  logic                   out_free;
  logic                   fire;

  bfbb_pkg::op_t          fin_op;
  logic                   fin_bad;
  logic                   fin_found;
  logic [IDXW-1:0]        fin_best;
  logic [SIZE_BITS-1:0]   fin_size;
  logic [SIZE_BITS-1:0]   fin_req;

  logic                   reuse;
  logic                   full;
  bfbb_pkg::status_t      res_status;
  logic [IDXW-1:0]        res_idx;
  logic [SIZE_BITS-1:0]   res_size;
  logic [IDXW+5:0]        idx_wide;
  logic [SIZE_BITS+23:0]  size_wide;

  logic                   rsp_valid;
  bfbb_pkg::status_t      rsp_status;
  logic [5:0]             rsp_index;
  logic [23:0]            rsp_size;

  assign request.ready = (state == bfbb_pkg::CS_IDLE);
  assign accept        = request.valid && request.ready;
  assign is_release    = (request.operation == bfbb_pkg::OP_RELEASE);
  assign req_wide      = {{SIZE_BITS{1'b0}}, request.request_size};
  assign rel_wide      = (CNTW+6)'(request.release_index);
  assign cnt_wide      = (CNTW+6)'(count);
  assign bad_index     = (rel_wide >= cnt_wide);

  assign head_ctl.valid = accept && !(is_release && bad_index);
  assign head_ctl.op    = is_release ? bfbb_pkg::OP_RELEASE : bfbb_pkg::OP_ASSIGN;
  assign head_ctl.found = 1'b0;
  assign head_req       = req_wide[SIZE_BITS-1:0];
  assign head_best      = is_release ? rel_wide[IDXW-1:0] : '0;
  assign head_size      = '0;

  assign out_free = !rsp_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bfbb_pkg::CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    fire       = 1'b0;
    case (state)
      bfbb_pkg::CS_IDLE: begin
        if (accept) begin
          state_next = (is_release && bad_index) ? bfbb_pkg::CS_DONE : bfbb_pkg::CS_SCAN;
        end
      end
      bfbb_pkg::CS_SCAN: begin
        if (tail_ctl.valid) begin
          state_next = bfbb_pkg::CS_DONE;
        end
      end
      bfbb_pkg::CS_DONE: begin
        if (out_free) begin
          fire       = 1'b1;
          state_next = bfbb_pkg::CS_IDLE;
        end
      end
      default: state_next = bfbb_pkg::CS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fin_op  <= is_release ? bfbb_pkg::OP_RELEASE : bfbb_pkg::OP_ASSIGN;
      fin_bad <= is_release && bad_index;
    end
    if (state == bfbb_pkg::CS_SCAN && tail_ctl.valid) begin
      fin_found <= tail_ctl.found;
      fin_best  <= tail_best;
      fin_size  <= tail_size;
      fin_req   <= tail_req;
    end
  end

  assign reuse = fin_found &&
                 ({{bfbb_pkg::REUSE_SHIFT{1'b0}}, fin_size} <
                  {fin_req, {bfbb_pkg::REUSE_SHIFT{1'b0}}});
  assign full  = (count == CNTW'(ENTRIES));

  always_comb begin
    res_status = bfbb_pkg::STATUS_BAD_IDX;
    res_idx    = '0;
    res_size   = '0;
    commit     = '0;
    if (fin_op == bfbb_pkg::OP_RELEASE) begin
      if (!fin_bad) begin
        res_status      = bfbb_pkg::STATUS_RELEASED;
        res_idx         = fin_best;
        res_size        = fin_size;
        commit.clr_busy = fire;
      end
    end else if (reuse) begin
      res_status      = bfbb_pkg::STATUS_REUSED;
      res_idx         = fin_best;
      res_size        = fin_size;
      commit.set_busy = fire;
    end else if (full) begin
      res_status = bfbb_pkg::STATUS_FULL;
    end else begin
      res_status   = bfbb_pkg::STATUS_APPENDED;
      res_idx      = count[IDXW-1:0];
      res_size     = fin_req;
      commit.write = fire;
    end
  end

  assign commit_idx  = res_idx;
  assign commit_size = fin_req;
  assign idx_wide    = (IDXW+6)'(res_idx);
  assign size_wide   = {24'd0, res_size};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (commit.write) begin
      count <= count + CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire) begin
      rsp_valid <= 1'b1;
    end else if (result.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp_status <= res_status;
      rsp_index  <= idx_wide[5:0];
      rsp_size   <= size_wide[23:0];
    end
  end

  assign result.valid       = rsp_valid;
  assign result.status      = rsp_status;
  assign result.entry_index = rsp_index;
  assign result.entry_size  = rsp_size;

endmodule

@@ sim/best_fit_buffer_bank_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_fit_buffer_bank_top_tb
// Drives assign and release requests into the buffer bank: a short directed
// run over the zero-size, wide-size and bad-index cases, then random traffic
// that fills the table, reuses freed entries and hits the full condition.
// A predictor tracks the entry table and every result transfer is checked
// in order against it.
// ----------------------------------------------------------------------------
module best_fit_buffer_bank_top_tb;

  localparam int ENTRIES   = 64;
  localparam int RANDOM_OPS = 630;

  typedef struct {
    bfbb_pkg::op_t op;
    logic [23:0]   size;
    logic [5:0]    index;
    bit            drain;
  } bank_op_t;

  typedef struct {
    bfbb_pkg::status_t status;
    logic [5:0]        index;
    logic [23:0]       size;
  } bank_result_t;

  logic clk;
  logic rst;

  bfbb_req_if req_ch ();
  bfbb_rsp_if rsp_ch ();

  best_fit_buffer_bank_top uut (
    .clk     (clk),
    .rst     (rst),
    .request (req_ch),
    .result  (rsp_ch)
  );

  logic [23:0]  bank_size [ENTRIES];
  bit           bank_busy [ENTRIES];
  int unsigned  bank_live;

  bank_op_t     pending_ops[$];
  bank_result_t expected_results[$];
  bank_op_t     cur_op;
  bank_result_t got_want;
  int           total_ops;
  int           accepted_ops;
  int           error_count;
  int           gap_left;
  int           burst_left;
  logic [31:0]  stall_bits;
  logic [4:0]   stall_pos;

  function automatic bank_result_t predict_bank(bank_op_t it);
    bank_result_t r;
    bit           found;
    int unsigned  best;
    logic [23:0]  best_size;
    logic [26:0]  reuse_limit;
    found     = 1'b0;
    best      = 0;
    best_size = '0;
    r.status  = bfbb_pkg::STATUS_BAD_IDX;
    r.index   = '0;
    r.size    = '0;
    if (it.op == bfbb_pkg::OP_RELEASE) begin
      if (it.index < bank_live) begin
        bank_busy[it.index] = 1'b0;
        r.status = bfbb_pkg::STATUS_RELEASED;
        r.index  = it.index;
        r.size   = bank_size[it.index];
      end
      return r;
    end
    for (int unsigned i = 0; i < bank_live; i++) begin
      if (!bank_busy[i[5:0]] && it.size <= bank_size[i[5:0]] &&
          (!found || bank_size[i[5:0]] < best_size)) begin
        found     = 1'b1;
        best      = i;
        best_size = bank_size[i[5:0]];
      end
    end
    reuse_limit = {it.size, 3'b000};
    if (found && {3'b000, best_size} < reuse_limit) begin
      bank_busy[best[5:0]] = 1'b1;
      r.status = bfbb_pkg::STATUS_REUSED;
      r.index  = best[5:0];
      r.size   = best_size;
    end else if (bank_live >= ENTRIES) begin
      r.status = bfbb_pkg::STATUS_FULL;
    end else begin
      bank_size[bank_live[5:0]] = it.size;
      bank_busy[bank_live[5:0]] = 1'b1;
      r.status = bfbb_pkg::STATUS_APPENDED;
      r.index  = bank_live[5:0];
      r.size   = it.size;
      bank_live = bank_live + 1;
    end
    return r;
  endfunction

  function automatic logic [23:0] random_size();
    logic [23:0] base;
    case ($urandom_range(0, 9))
      0: return 24'($urandom());
      1: begin
        case ($urandom_range(0, 2))
          0: return 24'h0;
          1: return 24'h1;
          default: return 24'hFFFFFF;
        endcase
      end
      default: begin
        base = 24'h1 << $urandom_range(3, 20);
        return 24'(base + $urandom_range(0, base));
      end
    endcase
  endfunction

  task automatic push_op(bfbb_pkg::op_t op, logic [23:0] size, logic [5:0] index, bit drain);
    bank_op_t it;
    it.op    = op;
    it.size  = size;
    it.index = index;
    it.drain = drain;
    pending_ops.push_back(it);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("best_fit_buffer_bank_top_tb NOT OK");
    $finish;
  end

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid         <= 1'b0;
      req_ch.operation     <= bfbb_pkg::OP_ASSIGN;
      req_ch.request_size  <= '0;
      req_ch.release_index <= '0;
      gap_left             <= 0;
      burst_left           <= 4;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        expected_results.push_back(predict_bank(cur_op));
        accepted_ops <= accepted_ops + 1;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (gap_left > 0) begin
          gap_left     <= gap_left - 1;
          req_ch.valid <= 1'b0;
        end else if (pending_ops.size() > 0 &&
                     !(pending_ops[0].drain && expected_results.size() != 0)) begin
          cur_op               = pending_ops.pop_front();
          req_ch.valid         <= 1'b1;
          req_ch.operation     <= cur_op.op;
          req_ch.request_size  <= cur_op.size;
          req_ch.release_index <= cur_op.index;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result backpressure
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_bits   <= 32'hFFFF_FFFF;
      stall_pos    <= 5'd0;
    end else begin
      rsp_ch.ready <= stall_bits[stall_pos];
      if (stall_pos == 5'd31) begin
        stall_pos <= 5'd0;
        case ($urandom_range(0, 9))
          0, 1, 2: stall_bits <= 32'hFFFF_FFFF;
          3:       stall_bits <= $urandom() & $urandom();
          4, 5:    stall_bits <= $urandom() | $urandom();
          default: stall_bits <= $urandom();
        endcase
      end else begin
        stall_pos <= stall_pos + 5'd1;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("result transfer with nothing pending: status %0d index %0d size %0h",
               rsp_ch.status, rsp_ch.entry_index, rsp_ch.entry_size);
        error_count++;
      end else begin
        got_want = expected_results.pop_front();
        if (rsp_ch.status !== got_want.status) begin
          $error("status: expected %0d, got %0d", got_want.status, rsp_ch.status);
          error_count++;
        end
        if (rsp_ch.entry_index !== got_want.index) begin
          $error("entry_index: expected %0d, got %0d", got_want.index, rsp_ch.entry_index);
          error_count++;
        end
        if (rsp_ch.entry_size !== got_want.size) begin
          $error("entry_size: expected %0h, got %0h", got_want.size, rsp_ch.entry_size);
          error_count++;
        end
      end
    end
  end

  initial begin
    bit drain;
    req_ch.valid         = 1'b0;
    req_ch.operation     = bfbb_pkg::OP_ASSIGN;
    req_ch.request_size  = '0;
    req_ch.release_index = '0;
    rsp_ch.ready         = 1'b0;
    error_count          = 0;
    accepted_ops         = 0;
    bank_live            = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      bank_size[i[5:0]] = '0;
      bank_busy[i[5:0]] = 1'b0;
    end
    rst = 1'b1;

    // release on an empty table, zero-size requests, no-wrap reuse limit
    push_op(bfbb_pkg::OP_RELEASE, 24'hFFFFFF, 6'd0, 1'b0);
    push_op(bfbb_pkg::OP_ASSIGN, 24'h0, 6'd63, 1'b0);
    push_op(bfbb_pkg::OP_ASSIGN, 24'h0, 6'd0, 1'b0);
    push_op(bfbb_pkg::OP_RELEASE, 24'h0, 6'd0, 1'b0);
    push_op(bfbb_pkg::OP_ASSIGN, 24'h0, 6'd0, 1'b0);
    push_op(bfbb_pkg::OP_ASSIGN, 24'hFFFFFF, 6'd0, 1'b0);
    push_op(bfbb_pkg::OP_RELEASE, 24'h0, 6'd3, 1'b0);
    push_op(bfbb_pkg::OP_ASSIGN, 24'hFFFFFF, 6'd0, 1'b0);
    push_op(bfbb_pkg::OP_RELEASE, 24'h0, 6'd3, 1'b0);
    push_op(bfbb_pkg::OP_ASSIGN, 24'h200000, 6'd0, 1'b0);
    push_op(bfbb_pkg::OP_RELEASE, 24'h0, 6'd3, 1'b0);
    push_op(bfbb_pkg::OP_ASSIGN, 24'h1FFFFF, 6'd0, 1'b0);
    push_op(bfbb_pkg::OP_ASSIGN, 24'd100, 6'd0, 1'b0);
    push_op(bfbb_pkg::OP_ASSIGN, 24'd100, 6'd0, 1'b0);
    push_op(bfbb_pkg::OP_RELEASE, 24'h0, 6'd5, 1'b0);
    push_op(bfbb_pkg::OP_RELEASE, 24'h0, 6'd6, 1'b0);
    push_op(bfbb_pkg::OP_ASSIGN, 24'd100, 6'd0, 1'b0);
    push_op(bfbb_pkg::OP_ASSIGN, 24'd50, 6'd0, 1'b0);
    push_op(bfbb_pkg::OP_RELEASE, 24'h0, 6'd63, 1'b0);
    push_op(bfbb_pkg::OP_RELEASE, 24'h0, 6'd6, 1'b0);
    push_op(bfbb_pkg::OP_RELEASE, 24'h0, 6'd6, 1'b0);
    push_op(bfbb_pkg::OP_RELEASE, 24'h0, 6'd7, 1'b1);

    for (int n = 0; n < RANDOM_OPS; n++) begin
      drain = (n % 150 == 75);
      if ($urandom_range(0, 99) < 55) begin
        push_op(bfbb_pkg::OP_ASSIGN, random_size(), 6'($urandom()), drain);
      end else begin
        push_op(bfbb_pkg::OP_RELEASE, 24'($urandom()), 6'($urandom_range(0, 63)), drain);
      end
    end
    total_ops = pending_ops.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (accepted_ops != total_ops) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (ENTRIES + 16) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("best_fit_buffer_bank_top_tb OK");
    end else begin
      $display("best_fit_buffer_bank_top_tb NOT OK");
    end
    $finish;
  end

endmodule
